// ===== rtl/core/gcb_pkg.sv =====
// Shared types and constants for the glyph cell blitter.
// Holds the command and result transfer structs and the default geometry.
// No dependencies.
package gcb_pkg;

	localparam int ADDR_W        = 20;
	localparam int PIX_W         = 9;
	localparam int FONT_IDX_W    = 13;
	localparam int CHAR_W        = 7;
	localparam int POS_W         = 9;
	localparam int COLOR_W       = 8;
	localparam int GLYPH_CNT_W   = 3;   // glyph row and column, eight bytes per glyph row
	localparam int PLANE_SHIFT   = 18;  // each plane is 0x40000 words

	localparam int DEF_PLANE_WIDTH  = 512;
	localparam int DEF_GLYPH_WIDTH  = 6;
	localparam int DEF_GLYPH_HEIGHT = 8;
	localparam int DEF_FONT_BYTES   = 8192;

	localparam logic [1:0] CMD_FONT_WRITE = 2'd0;
	localparam logic [1:0] CMD_RUN_START  = 2'd1;
	localparam logic [1:0] CMD_DRAW_CHAR  = 2'd2;

	typedef struct packed {
		logic [1:0]            command;
		logic [FONT_IDX_W-1:0] font_index;
		logic [7:0]            font_byte;
		logic [CHAR_W-1:0]     char_code;
		logic [1:0]            plane_select;
		logic [POS_W-1:0]      start_x;
		logic [POS_W-1:0]      start_y;
		logic [COLOR_W-1:0]    color_offset;
		logic                  opaque_flag;
	} gcb_cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] word_address;
		logic [PIX_W-1:0]  pixel_value;
		logic              last_write;
	} gcb_pix_t;

endpackage

// ===== rtl/core/glyph_cell_blitter_unit.sv =====
// Glyph cell blitter top level: font store, text cursor and pixel write scan.
// Depends on gcb_pkg for the transfer structs, command codes and defaults.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  cmd     | in        | cmd_valid/cmd_ready  | gcb_cmd_t: font load, run, draw
//  pix     | out       | pix_valid/pix_ready  | gcb_pix_t: one graphics write
//
// Font load and run start leave the unit idle, ready for the next command. A draw
// scans every glyph pixel (GLYPH_WIDTH * GLYPH_HEIGHT, 48 by default) and then
// drains; its pace is set by the single read port of the font store: one font byte
// per cycle while pix does not stall.
// Reset clears the cursor, colour, opaque flag and all control; the font store
// is not initialised and must be loaded before use.
// A stall on pix freezes the scan; a new command is taken while the final
// write of the previous character still waits in the output register.
module glyph_cell_blitter_unit #(
	parameter int PLANE_WIDTH  = gcb_pkg::DEF_PLANE_WIDTH,
	parameter int GLYPH_WIDTH  = gcb_pkg::DEF_GLYPH_WIDTH,
	parameter int GLYPH_HEIGHT = gcb_pkg::DEF_GLYPH_HEIGHT,
	parameter int FONT_BYTES   = gcb_pkg::DEF_FONT_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  gcb_pkg::gcb_cmd_t cmd,
	output logic              pix_valid,
	input  logic              pix_ready,
	output gcb_pkg::gcb_pix_t pix
);
	import gcb_pkg::*;

	localparam int FB_W   = $clog2(FONT_BYTES);
	localparam int RED_W  = FONT_IDX_W + 4;   // room for FONT_BYTES shifted by three

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAW,
		ST_FLUSH
	} state_t;

	state_t                 state_q;
	logic [ADDR_W-1:0]      cursor_q;
	logic [ADDR_W-1:0]      row_addr_q;
	logic [COLOR_W-1:0]     color_q;
	logic                   opaque_q;
	logic [CHAR_W-1:0]      char_q;
	logic [GLYPH_CNT_W-1:0] col_q;
	logic [GLYPH_CNT_W-1:0] row_q;

	// read stage: font byte and its target address
	logic                   valid_s1;
	logic [ADDR_W-1:0]      waddr_s1;
	logic [7:0]             font_s1;

	// one write held back so the final write of a character can be flagged
	logic                   pend_valid_q;
	gcb_pix_t               pend_q;
	logic                   out_valid_q;
	gcb_pix_t               out_q;

	logic [7:0]             font_mem [FONT_BYTES];

	logic                   cmd_xfer;
	logic                   adv;
	logic                   rd_en;
	logic                   font_wr;
	logic                   emit;
	logic                   flush_go;
	logic                   push_pend;
	logic                   push_last;
	logic [RED_W-1:0]       font_addr;
	logic [FB_W-1:0]        rd_idx;
	gcb_pix_t               new_pix;

	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_xfer  = cmd_valid && cmd_ready;
	assign pix_valid = out_valid_q;
	assign pix       = out_q;

	// the scan may move only when the output register is free or being drained
	assign adv   = !out_valid_q || pix_ready;
	assign rd_en = (state_q == ST_DRAW) && adv;

	assign font_wr = cmd_xfer && (cmd.command == CMD_FONT_WRITE)
		&& ({1'b0, cmd.font_index} < (FONT_IDX_W+1)'(FONT_BYTES));

	// glyph byte address, wrapped into the store by conditional subtraction
	always_comb begin
		font_addr = RED_W'({char_q, row_q, col_q});
		for (int k = 3; k >= 0; k--) begin
			if (font_addr >= (RED_W'(FONT_BYTES) << k)) begin
				font_addr = font_addr - (RED_W'(FONT_BYTES) << k);
			end
		end
	end
	assign rd_idx = font_addr[FB_W-1:0];

	// zero pixels are dropped unless the run is opaque
	assign emit = valid_s1 && ((font_s1 != 8'd0) || opaque_q);

	// end of a draw once the read stage is empty; a new write pushes the held one out
	assign flush_go  = (state_q == ST_FLUSH) && adv && !valid_s1;
	assign push_pend = adv && emit && pend_valid_q;
	assign push_last = flush_go && pend_valid_q;

	always_comb begin
		new_pix.word_address = waddr_s1;
		new_pix.pixel_value  = (font_s1 != 8'd0)
			? ({1'b0, font_s1} + {1'b0, color_q}) : '0;
		new_pix.last_write   = 1'b0;
	end

	// font store: written by load commands, read during the draw scan
	always_ff @(posedge clk) begin
		if (font_wr) begin
			font_mem[cmd.font_index[FB_W-1:0]] <= cmd.font_byte;
		end
		if (rd_en) begin
			font_s1 <= font_mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cursor_q     <= '0;
			row_addr_q   <= '0;
			color_q      <= '0;
			opaque_q     <= 1'b0;
			char_q       <= '0;
			col_q        <= '0;
			row_q        <= '0;
			valid_s1     <= 1'b0;
			waddr_s1     <= '0;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			// load the held write into the output, flagged as last at the end of a draw;
			// otherwise drop the output once taken
			if (push_pend || push_last) begin
				out_q       <= {pend_q.word_address, pend_q.pixel_value, push_last};
				out_valid_q <= 1'b1;
			end else if (pix_ready) begin
				out_valid_q <= 1'b0;
			end

			if (adv && emit) begin
				pend_valid_q <= 1'b1;
			end else if (flush_go) begin
				pend_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_xfer) begin
						case (cmd.command)
							CMD_RUN_START: begin
								cursor_q <= ADDR_W'({cmd.plane_select, {PLANE_SHIFT{1'b0}}})
									+ ADDR_W'(ADDR_W'(cmd.start_y) * ADDR_W'(PLANE_WIDTH))
									+ ADDR_W'(cmd.start_x);
								color_q  <= cmd.color_offset;
								opaque_q <= cmd.opaque_flag;
							end
							CMD_DRAW_CHAR: begin
								char_q     <= cmd.char_code;
								col_q      <= '0;
								row_q      <= '0;
								row_addr_q <= cursor_q;
								cursor_q   <= cursor_q + ADDR_W'(GLYPH_WIDTH);
								state_q    <= ST_DRAW;
							end
							default: begin
								// font loads go straight to the store; unused codes do nothing
							end
						endcase
					end
				end
				ST_DRAW: begin
					if (adv) begin
						waddr_s1 <= row_addr_q + ADDR_W'(col_q);
						if (col_q == GLYPH_CNT_W'(GLYPH_WIDTH - 1)) begin
							col_q      <= '0;
							row_addr_q <= row_addr_q + ADDR_W'(PLANE_WIDTH);
							if (row_q == GLYPH_CNT_W'(GLYPH_HEIGHT - 1)) begin
								state_q <= ST_FLUSH;
							end else begin
								row_q <= row_q + GLYPH_CNT_W'(1);
							end
						end else begin
							col_q <= col_q + GLYPH_CNT_W'(1);
						end
					end
				end
				ST_FLUSH: begin
					// the held write leaves as the last one above; return to idle
					if (flush_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (adv) begin
				valid_s1 <= (state_q == ST_DRAW);
				if (emit) begin
					pend_q <= new_pix;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_valid_q)
		else $error("held write left over outside a draw");

	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> state_q != ST_IDLE)
		else $error("read stage busy while idle");

	a_draw_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer && cmd.command == CMD_DRAW_CHAR |=> state_q == ST_DRAW)
		else $error("draw command did not start the scan");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.last_write |-> !pend_valid_q)
		else $error("write held back behind the last write");
`endif

endmodule
